>>> sv/hshf_pkg.sv
// Shared constants and types for the host show/hide filter.
`timescale 1ns / 1ps
`default_nettype none
package hshf_pkg;

  // Number of entries in the table, one compare cell per entry
  localparam int TABLE_DEPTH = 16;
  // Width of the fill count, which can hold TABLE_DEPTH itself
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W = 32;

  // Command codes carried by an input beat
  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_CHECK = 2'd2
  } cmd_t;

  // Token that walks the cell row, one cell per cycle
  typedef struct packed {
    logic              vld;
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] host;
    logic [ADDR_W-1:0] foreign;
    logic              flag;
    logic [CNT_W-1:0]  count;
    logic              hit;
    logic              mark;
    logic              appended;
  } tok_t;

endpackage
`default_nettype wire

>>> sv/hshf_cell.sv
// One table entry: address and mark, with the compare and update logic of that entry.
`timescale 1ns / 1ps
`default_nettype none
module hshf_cell (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [hshf_pkg::CNT_W-1:0] cell_idx,
  input  wire hshf_pkg::tok_t           tok_i,
  output hshf_pkg::tok_t                tok_o
);
  import hshf_pkg::*;

  logic [ADDR_W-1:0] addr_r;
  logic              mark_r;
  logic              vld_r;
  tok_t              tok_r;
  tok_t              tok_nxt;
  logic              live;
  logic              is_set;
  logic              is_check;
  logic              match;
  logic              append;

  // entry is in use when its index lies below the fill count
  assign live     = cell_idx < tok_i.count;
  assign is_set   = tok_i.cmd == CMD_SET;
  assign is_check = tok_i.cmd == CMD_CHECK;
  assign match    = tok_i.vld && !tok_i.hit && live && (is_set || is_check) &&
                    ((addr_r == tok_i.host) || (is_check && addr_r == tok_i.foreign));
  // first free entry takes a new address that found no match
  assign append   = tok_i.vld && !tok_i.hit && is_set && (cell_idx == tok_i.count);

  // token update as it passes this entry
  always_comb begin
    tok_nxt = tok_i;
    if (match) begin
      tok_nxt.hit  = 1'b1;
      tok_nxt.mark = mark_r;
    end
    if (append) begin
      tok_nxt.hit      = 1'b1;
      tok_nxt.appended = 1'b1;
    end
  end

  // entry store, written on append or on a set that hits
  always_ff @(posedge clk) begin
    if (append) begin
      addr_r <= tok_i.host;
      mark_r <= tok_i.flag;
    end else if (match && is_set) begin
      mark_r <= tok_i.flag;
    end
  end

  // token stage to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= tok_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  always_comb begin
    tok_o     = tok_r;
    tok_o.vld = vld_r;
  end

endmodule
`default_nettype wire

>>> sv/host_show_hide_filter.sv
// Top level of the host show/hide filter: cell row, fill count and result buffering.
`timescale 1ns / 1ps
`default_nettype none
// Ordered first-match table of IPv4 host addresses with a show/hide mark per entry.
// Each accepted beat becomes a token that walks a row of TABLE_DEPTH compare cells,
// one cell per cycle, so the length of the cell row sets the time that an item
// takes from acceptance to a result beat. One item is in the row at a time. A
// finished result waits in an output register with one spare slot behind it, so
// the next item is taken while the previous result is still stalled.
// The table needs no clearing pass: a fill count marks which entries are in use,
// and a clear beat simply zeroes it.
module host_show_hide_filter (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_command,
  input  wire logic [hshf_pkg::ADDR_W-1:0] in_host_addr,
  input  wire logic [hshf_pkg::ADDR_W-1:0] in_foreign_addr,
  input  wire logic                        in_show_flag,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_verdict,
  output logic                             out_changed,
  output logic                             out_table_full
);
  import hshf_pkg::*;

  typedef struct packed {
    logic verdict;
    logic changed;
    logic full;
  } res_t;

  tok_t             chain [0:TABLE_DEPTH];
  tok_t             tail;
  logic             in_acc;
  logic             out_acc;
  logic             busy_r;
  logic             busy_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_vld_r;
  logic             out_vld_nxt;
  logic             hold_vld_r;
  logic             hold_vld_nxt;
  res_t             out_res_r;
  res_t             out_res_nxt;
  res_t             hold_res_r;
  res_t             hold_res_nxt;
  res_t             tail_res;

  assign in_stall = busy_r || hold_vld_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_vld_r && !out_stall;

  // token entering the first cell
  always_comb begin
    chain[0]          = '0;
    chain[0].vld      = in_acc;
    chain[0].cmd      = in_command;
    chain[0].host     = in_host_addr;
    chain[0].foreign  = in_foreign_addr;
    chain[0].flag     = in_show_flag;
    chain[0].count    = count_r;
  end

  // row of compare cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    hshf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (CNT_W'(i)),
      .tok_i    (chain[i]),
      .tok_o    (chain[i+1])
    );
  end

  assign tail = chain[TABLE_DEPTH];

  // result of the token leaving the row
  always_comb begin
    tail_res = '0;
    unique case (tail.cmd)
      CMD_SET: begin
        tail_res.changed = tail.appended;
        tail_res.full    = !tail.hit;
      end
      CMD_CLEAR: begin
        tail_res.changed = tail.count != '0;
      end
      CMD_CHECK: begin
        tail_res.verdict = tail.hit ? tail.mark : 1'b1;
      end
      default: begin
        tail_res = '0;
      end
    endcase
  end

  // fill count, busy flag and output buffering
  always_comb begin
    count_nxt    = count_r;
    busy_nxt     = busy_r;
    out_vld_nxt  = out_vld_r;
    out_res_nxt  = out_res_r;
    hold_vld_nxt = hold_vld_r;
    hold_res_nxt = hold_res_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
    end
    // a spare-slot result moves up when the output beat is taken
    if (out_acc) begin
      out_vld_nxt = hold_vld_r;
      out_res_nxt = hold_res_r;
      hold_vld_nxt = 1'b0;
    end
    if (tail.vld) begin
      busy_nxt = 1'b0;
      if (tail.cmd == CMD_CLEAR) begin
        count_nxt = '0;
      end else if (tail.appended) begin
        count_nxt = tail.count + CNT_W'(1);
      end
      if (!out_vld_r || out_acc) begin
        out_vld_nxt = 1'b1;
        out_res_nxt = tail_res;
      end else begin
        hold_vld_nxt = 1'b1;
        hold_res_nxt = tail_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      busy_r     <= 1'b0;
      out_vld_r  <= 1'b0;
      hold_vld_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      busy_r     <= busy_nxt;
      out_vld_r  <= out_vld_nxt;
      hold_vld_r <= hold_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    hold_res_r <= hold_res_nxt;
  end

  assign out_valid      = out_vld_r;
  assign out_verdict    = out_res_r.verdict;
  assign out_changed    = out_res_r.changed;
  assign out_table_full = out_res_r.full;

  // a token only leaves the row while its item is marked busy
  a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> busy_r)
    else $error("token left the cell row with no item in flight");

  // the spare slot is only used behind a waiting output beat
  a_hold_order: assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r |-> out_vld_r)
    else $error("spare result slot filled while output empty");

  // fill count never exceeds the table
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // an append grows the table by exactly one entry
  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (tail.vld && tail.appended) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("append did not advance the fill count");

endmodule
`default_nettype wire

>>> tb/hshf_result_checker.sv
// Result checker for the host show/hide filter: tracks the table, predicts and compares beats.
`timescale 1ns / 1ps
module hshf_result_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic [1:0]                  in_command,
  input  wire logic [hshf_pkg::ADDR_W-1:0] in_host_addr,
  input  wire logic [hshf_pkg::ADDR_W-1:0] in_foreign_addr,
  input  wire logic                        in_show_flag,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic                        out_verdict,
  input  wire logic                        out_changed,
  input  wire logic                        out_table_full,
  output int                               mismatch_count,
  output int                               awaited_count
);
  import hshf_pkg::*;

  typedef struct packed {
    logic verdict;
    logic changed;
    logic table_full;
  } filter_result_t;

  // Shadow copy of the filter table
  logic [ADDR_W-1:0] host_tbl [TABLE_DEPTH];
  logic              mark_tbl [TABLE_DEPTH];
  int unsigned       fill;

  // Results owed by the block, oldest first
  filter_result_t awaited_results [$];

  // Index of the first entry equal to either address, or fill if none
  function automatic int unsigned first_hit(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b);
    for (int unsigned i = 0; i < fill; i++) begin
      if (host_tbl[i] == a || host_tbl[i] == b) return i;
    end
    return fill;
  endfunction

  // Apply one input beat to the shadow table and return the result it owes
  function automatic filter_result_t predict_filter_result(logic [1:0] cmd,
                                                           logic [ADDR_W-1:0] host,
                                                           logic [ADDR_W-1:0] foreign,
                                                           logic flag);
    filter_result_t res;
    int unsigned    idx;
    res = '0;
    case (cmd)
      CMD_SET: begin
        idx = first_hit(host, host);
        if (idx < fill) begin
          // known address: mark updated in place, even on a full table
          mark_tbl[idx] = flag;
        end else if (fill < TABLE_DEPTH) begin
          host_tbl[fill] = host;
          mark_tbl[fill] = flag;
          fill++;
          res.changed = 1'b1;
        end else begin
          res.table_full = 1'b1;
        end
      end
      CMD_CLEAR: begin
        res.changed = (fill != 0);
        fill = 0;
      end
      CMD_CHECK: begin
        idx = first_hit(host, foreign);
        // no match answers show
        res.verdict = (idx < fill) ? mark_tbl[idx] : 1'b1;
      end
      default: ;  // unused code: state untouched, all fields zero
    endcase
    return res;
  endfunction

  function automatic void compare_field(string name, logic exp_v, logic act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0b, got %0b", $realtime, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    filter_result_t exp_r;
    if (!rst_n) begin
      fill = 0;
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: expected none, got %0b/%0b/%0b",
                   $realtime, out_verdict, out_changed, out_table_full);
          mismatch_count++;
        end else begin
          exp_r = awaited_results.pop_front();
          compare_field("verdict", exp_r.verdict, out_verdict);
          compare_field("changed", exp_r.changed, out_changed);
          compare_field("table_full", exp_r.table_full, out_table_full);
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(predict_filter_result(in_command, in_host_addr,
                                                        in_foreign_addr, in_show_flag));
    end
    awaited_count = awaited_results.size();
  end

endmodule

>>> tb/tb_host_show_hide_filter.sv
// Testbench top for the host show/hide filter: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_host_show_hide_filter;
  import hshf_pkg::*;

  localparam logic [1:0] CMD_UNUSED      = 2'd3;
  localparam int         POOL_SIZE       = 18;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         WATCHDOG_LIMIT  = 3000;
  localparam int         PHASE_ITEMS     = 270;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_command = '0;
  logic [ADDR_W-1:0] in_host_addr = '0;
  logic [ADDR_W-1:0] in_foreign_addr = '0;
  logic              in_show_flag = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_verdict;
  logic              out_changed;
  logic              out_table_full;

  int                mismatch_count;
  int                awaited_count;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                hold_req_seq = 0;
  int                quiet_cycles = 0;
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  host_show_hide_filter DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_host_addr   (in_host_addr),
    .in_foreign_addr(in_foreign_addr),
    .in_show_flag   (in_show_flag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_verdict    (out_verdict),
    .out_changed    (out_changed),
    .out_table_full (out_table_full)
  );

  hshf_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_host_addr   (in_host_addr),
    .in_foreign_addr(in_foreign_addr),
    .in_show_flag   (in_show_flag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_verdict    (out_verdict),
    .out_changed    (out_changed),
    .out_table_full (out_table_full),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: random stall, or a long hold-off when one is requested
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req_seq) begin
        hold_seen = hold_req_seq;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** host_show_hide_filter: FAILED **");
        $finish;
      end
    end
  end

  // Offer one beat, with random idle cycles ahead of it; returns on the falling edge
  task automatic send_beat(logic [1:0] cmd, logic [ADDR_W-1:0] host,
                           logic [ADDR_W-1:0] foreign, logic flag);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_host_addr    <= host;
    in_foreign_addr <= foreign;
    in_show_flag    <= flag;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Mostly pool addresses so that sets hit and checks match
  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 99) < 80) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic run_random(int n_items);
    int          w;
    logic [1:0]  cmd;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
    for (int i = 0; i < n_items; i++) begin
      // rare clears let the table fill up and overflow
      w = $urandom_range(0, 199);
      if (w < 90)       cmd = CMD_SET;
      else if (w < 194) cmd = CMD_CHECK;
      else if (w < 197) cmd = CMD_CLEAR;
      else              cmd = CMD_UNUSED;
      send_beat(cmd, pick_addr(), pick_addr(), 1'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty table, unused code, updates, first-match order, full table
    send_beat(CMD_CHECK, 32'h0A00_0001, 32'hC0A8_0001, 1'b0);
    send_beat(CMD_CLEAR, '0, '0, 1'b0);
    send_beat(CMD_UNUSED, '1, '1, 1'b1);
    send_beat(CMD_SET, '0, '1, 1'b0);
    send_beat(CMD_SET, '1, '0, 1'b1);
    send_beat(CMD_SET, '0, '0, 1'b1);
    send_beat(CMD_SET, '0, '0, 1'b0);
    send_beat(CMD_CHECK, '1, '0, 1'b1);
    send_beat(CMD_CHECK, 32'h1234_5678, '1, 1'b0);
    send_beat(CMD_CHECK, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0);
    for (int i = 0; i < TABLE_DEPTH - 2; i++)
      send_beat(CMD_SET, 32'h0A00_0001 + i, '0, 1'(i));
    send_beat(CMD_SET, 32'h1234_5678, '0, 1'b0);
    send_beat(CMD_SET, '1, '0, 1'b0);
    send_beat(CMD_CHECK, 32'h5555_AAAA, 32'h0A00_0001 + TABLE_DEPTH - 3, 1'b0);
    send_beat(CMD_CLEAR, '1, '1, 1'b1);

    // Random phases with different idle patterns
    run_random(PHASE_ITEMS);
    send_idle_pct = 50;
    run_random(PHASE_ITEMS);
    send_idle_pct  = 0;
    recv_stall_pct = 50;
    run_random(PHASE_ITEMS);
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    run_random(PHASE_ITEMS);

    // Back-pressure: long hold-off on the result side while beats keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req_seq++;
    run_random(60);

    in_valid <= 1'b0;
    while (awaited_count != 0) @(posedge clk);
    repeat (2 * TABLE_DEPTH + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** host_show_hide_filter: PASSED **");
    end else begin
      $display("** host_show_hide_filter: FAILED **");
    end
    $finish;
  end

endmodule
